// ===== design/sbs_pkg.sv =====
package sbs_pkg;

  localparam int SAMPLE_W = 32;
  localparam int CAPACITY_DEFAULT = 32;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       block_end;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sorted_value;
    logic                       final_flag;
    logic                       overflow_flag;
  } result_t;

  // Broadcast to every cell of the chain on an insertion.
  typedef struct packed {
    logic                       load;
    logic signed [SAMPLE_W-1:0] key;
  } cell_ctl_t;

endpackage

// ===== design/sbs_cell.sv =====
module sbs_cell (
  input  logic                                clk,
  input  sbs_pkg::cell_ctl_t                  ctl,
  input  logic                                occupied,
  input  logic                                left_gt,
  input  logic signed [sbs_pkg::SAMPLE_W-1:0] left_value,
  output logic signed [sbs_pkg::SAMPLE_W-1:0] value,
  output logic                                gt
);

  // An empty cell counts as larger than any key, so the chain's tail stays empty.
  assign gt = !occupied || (value > ctl.key);

  always_ff @(posedge clk) begin
    if (ctl.load && gt) begin
      if (left_gt) begin
        value <= left_value;
      end else begin
        value <= ctl.key;
      end
    end
  end

endmodule

// ===== design/sample_block_sorter_top.sv =====
// Block sorter for signed Q16.16 samples, built as a chain of compare-and-shift cells.
//
// Input: an item (sample plus block_end) is taken at a clock edge where start is high
// and busy is low. While a block is loading, busy stays low and one item is taken
// every cycle; each sample is inserted into the chain in the cycle it is taken.
// Samples beyond CAPACITY are dropped and mark the block as overflowed.
// An item with block_end set is inserted too and then releases the block: busy rises
// and stays high until every held sample has been read out. The results follow one
// per cycle on result, each marked by result_valid for one cycle; once busy is set,
// each is read from the chain and registered. The last result carries final_flag.
// Busy falls as the final result is registered, so the next block may start while
// that result is shown. The drain rate is set by the single read port of the chain.
// Configuration: cfg_data is written to the order bit when cfg_write is high
// (0 ascending, 1 descending); the bit is sampled when block_end is taken.
// Reset empties the store, clears the overflow mark and selects ascending order.
// The receiver cannot stall: every result is shown for exactly one cycle.
module sample_block_sorter_top #(
  parameter int CAPACITY = sbs_pkg::CAPACITY_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  sbs_pkg::sample_t sample,
  output logic             result_valid,
  output sbs_pkg::result_t result,
  input  logic             cfg_write,
  input  logic             cfg_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  logic                                descending;
  logic                                desc_sel;
  logic [CW-1:0]                       fill_count;
  logic [CW-1:0]                       drain_count;
  logic                                dropped_seen;
  logic                                accept;
  logic                                full;
  logic                                last_out;
  logic [CW-1:0]                       read_full;
  logic [IW-1:0]                       read_index;
  sbs_pkg::cell_ctl_t                  ctl;
  logic signed [sbs_pkg::SAMPLE_W-1:0] cell_value [CAPACITY];
  logic                                cell_gt [CAPACITY];

  assign accept   = start && !busy;
  assign full     = (fill_count == CW'(CAPACITY));
  assign ctl.load = accept && !full;
  assign ctl.key  = sample.sample_value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                                occ;
    logic                                lgt;
    logic signed [sbs_pkg::SAMPLE_W-1:0] lval;
    assign occ = (CW'(i) < fill_count);
    if (i == 0) begin : g_head
      assign lgt  = 1'b0;
      assign lval = ctl.key;
    end else begin : g_body
      assign lgt  = cell_gt[i-1];
      assign lval = cell_value[i-1];
    end
    sbs_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occupied  (occ),
      .left_gt   (lgt),
      .left_value(lval),
      .value     (cell_value[i]),
      .gt        (cell_gt[i])
    );
  end

  // The chain is kept ascending; descending output reads it from the top end.
  assign last_out   = (drain_count == (fill_count - CW'(1)));
  assign read_full  = desc_sel ? (fill_count - drain_count - CW'(1)) : drain_count;
  assign read_index = read_full[IW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      descending <= 1'b0;
    end else if (cfg_write) begin
      descending <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      fill_count   <= '0;
      drain_count  <= '0;
      dropped_seen <= 1'b0;
      desc_sel     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (accept) begin
        if (!full) begin
          fill_count <= fill_count + CW'(1);
        end
        dropped_seen <= dropped_seen | full;
        if (sample.block_end) begin
          busy        <= 1'b1;
          desc_sel    <= descending;
          drain_count <= '0;
        end
      end else if (busy) begin
        result_valid <= 1'b1;
        drain_count  <= drain_count + CW'(1);
        if (last_out) begin
          busy         <= 1'b0;
          fill_count   <= '0;
          dropped_seen <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      result.sorted_value  <= cell_value[read_index];
      result.final_flag    <= last_out;
      result.overflow_flag <= dropped_seen;
    end
  end

endmodule

// ===== design/sbs_checker.sv =====
module sbs_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input sbs_pkg::sample_t sample,
  input logic             result_valid,
  input sbs_pkg::result_t result
);

  // A result is only ever produced out of a draining cycle.
  a_result_from_drain: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result without a preceding drain cycle");

  // The block is released by the final result of the drain.
  a_final_frees: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.final_flag |-> !busy)
    else $error("still busy after the final result");

  // An item that ends the block starts the drain.
  a_end_starts_drain: assert property (@(posedge clk) disable iff (rst)
    start && !busy && sample.block_end |=> busy)
    else $error("block end did not start the drain");

  // Results of one block come out in consecutive cycles.
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.final_flag |=> result_valid)
    else $error("gap inside a block's results");

endmodule

bind sample_block_sorter_top sbs_checker u_sbs_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .sample      (sample),
  .result_valid(result_valid),
  .result      (result)
);

// ===== dv/tb_sample_block_sorter_top.sv =====
`timescale 1ns / 1ps

module tb_sample_block_sorter_top;

  localparam int CAP = sbs_pkg::CAPACITY_DEFAULT;
  localparam logic ORDER_BIT_ASC  = 1'b0;
  localparam logic ORDER_BIT_DESC = 1'b1;
  localparam int RANDOM_ITEMS = 24;
  localparam int DIRECTED_ROWS = 21;

  typedef enum logic [1:0] {ORDER_KEEP, ORDER_ASC, ORDER_DESC} order_cmd_e;

  typedef struct packed {
    order_cmd_e                         cmd;
    logic [5:0]                         fill;
    logic signed [sbs_pkg::SAMPLE_W-1:0] value;
    logic                               last;
    logic                               typed;
    sbs_pkg::result_t                   want;
  } directed_row_t;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  sbs_pkg::sample_t sample;
  logic             result_valid;
  sbs_pkg::result_t result;
  logic             cfg_write;
  logic             cfg_data;

  // Model of the chain: samples held smallest first.
  logic signed [sbs_pkg::SAMPLE_W-1:0] held_store [CAP];
  int                                  held_count;
  logic                                overflow_seen;
  logic                                order_desc;
  sbs_pkg::result_t                    pending_sorted[$];

  logic             typed_active;
  sbs_pkg::result_t typed_want;
  int               error_count;
  int               burst_left;
  directed_row_t    directed_rows [DIRECTED_ROWS];

  sample_block_sorter_top #(
    .CAPACITY(CAP)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .sample(sample),
    .result_valid(result_valid),
    .result(result),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report_mismatch(string msg);
    if (error_count < 40) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  task automatic enqueue_result(sbs_pkg::result_t r);
    pending_sorted = {pending_sorted, r};
  endtask

  // Inserts or drops an item; on block_end, queues the expected results in order.
  task automatic load_sample(sbs_pkg::sample_t s);
    int               pos;
    int               idx;
    sbs_pkg::result_t r;
    if (held_count >= CAP) begin
      overflow_seen = 1'b1;
    end else begin
      pos = held_count;
      while (pos > 0 && held_store[pos-1] > s.sample_value) begin
        held_store[pos] = held_store[pos-1];
        pos--;
      end
      held_store[pos] = s.sample_value;
      held_count++;
    end
    if (s.block_end) begin
      if (typed_active) begin
        enqueue_result(typed_want);
      end else begin
        for (int k = 0; k < held_count; k++) begin
          idx = order_desc ? held_count - 1 - k : k;
          r.sorted_value  = held_store[idx];
          r.final_flag    = (k == held_count - 1);
          r.overflow_flag = overflow_seen;
          enqueue_result(r);
        end
      end
      held_count    = 0;
      overflow_seen = 1'b0;
    end
  endtask

  task automatic check_sorted(sbs_pkg::result_t got);
    sbs_pkg::result_t want;
    if (pending_sorted.size() == 0) begin
      report_mismatch($sformatf("unexpected item, value %0d", got.sorted_value));
      return;
    end
    want = pending_sorted.pop_front();
    if (got.sorted_value !== want.sorted_value) begin
      report_mismatch($sformatf("sorted_value %0d, wanted %0d",
                                got.sorted_value, want.sorted_value));
    end
    if (got.final_flag !== want.final_flag) begin
      report_mismatch($sformatf("final_flag %b, wanted %b", got.final_flag, want.final_flag));
    end
    if (got.overflow_flag !== want.overflow_flag) begin
      report_mismatch($sformatf("overflow_flag %b, wanted %b",
                                got.overflow_flag, want.overflow_flag));
    end
  endtask

  // Results are checked before the item of the same edge is loaded.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid) begin
        check_sorted(result);
      end
      if (start && !busy) begin
        load_sample(sample);
      end
      if (cfg_write) begin
        order_desc = cfg_data;
      end
    end
  end

  // Called and returns at a falling edge; start stays high for a following item.
  task automatic put_item(logic signed [sbs_pkg::SAMPLE_W-1:0] value, logic last);
    start  = 1'b1;
    sample = '{sample_value: value, block_end: last};
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle(int cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic write_order(logic desc);
    start = 1'b0;
    while (pending_sorted.size() != 0 || busy) @(negedge clk);
    // Quiet cycles keep the write apart from the last item.
    repeat (4) @(negedge clk);
    cfg_write = 1'b1;
    cfg_data  = desc;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  function automatic logic signed [sbs_pkg::SAMPLE_W-1:0] random_sample();
    logic signed [sbs_pkg::SAMPLE_W-1:0] v;
    case ($urandom_range(0, 3))
      2: v = int'($urandom_range(0, 8)) - 4;
      3: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh7FFFFFFF;
          1: v = 32'sh80000000;
          2: v = '0;
          default: v = -32'sd1;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Bursts of back-to-back items with random gaps; some gaps are empty.
  task automatic pace_sender();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        idle($urandom_range(1, 6));
      end
    end
    burst_left--;
  endtask

  initial begin
    int block_len;
    int random_sent;
    int waited;

    rst           = 1'b1;
    start         = 1'b0;
    sample        = '0;
    cfg_write     = 1'b0;
    cfg_data      = ORDER_BIT_ASC;
    held_count    = 0;
    overflow_seen = 1'b0;
    order_desc    = ORDER_BIT_ASC;
    typed_active  = 1'b0;
    typed_want    = '0;
    error_count   = 0;
    burst_left    = 0;
    for (int i = 0; i < CAP; i++) held_store[i] = '0;

    directed_rows = '{
      '{ORDER_KEEP, 6'd0,  32'sh7FFFFFFF, 1'b1, 1'b1, '{32'sh7FFFFFFF, 1'b1, 1'b0}},
      '{ORDER_KEEP, 6'd0,  32'sh80000000, 1'b1, 1'b1, '{32'sh80000000, 1'b1, 1'b0}},
      '{ORDER_KEEP, 6'd0,  32'sd0,        1'b1, 1'b1, '{32'sd0, 1'b1, 1'b0}},
      // Equal samples must come out side by side.
      '{ORDER_KEEP, 6'd0,  32'sd5,        1'b0, 1'b0, '0},
      '{ORDER_KEEP, 6'd0,  -32'sd3,       1'b0, 1'b0, '0},
      '{ORDER_KEEP, 6'd0,  32'sd5,        1'b0, 1'b0, '0},
      '{ORDER_KEEP, 6'd0,  32'sd0,        1'b1, 1'b0, '0},
      '{ORDER_DESC, 6'd0,  32'sd1,        1'b0, 1'b0, '0},
      '{ORDER_KEEP, 6'd0,  -32'sd1,       1'b0, 1'b0, '0},
      '{ORDER_KEEP, 6'd0,  32'sh7FFFFFFF, 1'b0, 1'b0, '0},
      '{ORDER_KEEP, 6'd0,  32'sh80000000, 1'b1, 1'b0, '0},
      '{ORDER_DESC, 6'd0,  32'sd42,       1'b1, 1'b1, '{32'sd42, 1'b1, 1'b0}},
      // The order is flipped while a block is half loaded, both ways.
      '{ORDER_ASC,  6'd0,  32'sd10,       1'b0, 1'b0, '0},
      '{ORDER_KEEP, 6'd0,  32'sd20,       1'b0, 1'b0, '0},
      '{ORDER_DESC, 6'd0,  32'sd15,       1'b1, 1'b0, '0},
      '{ORDER_KEEP, 6'd0,  32'sd30,       1'b0, 1'b0, '0},
      '{ORDER_ASC,  6'd0,  -32'sd30,      1'b1, 1'b0, '0},
      // Exactly full, then a descending block whose block_end item is itself dropped.
      '{ORDER_KEEP, 6'd31, 32'sd7,        1'b1, 1'b0, '0},
      '{ORDER_DESC, 6'd32, 32'sd8,        1'b1, 1'b0, '0},
      // The overflow mark must not survive into the next block.
      '{ORDER_KEEP, 6'd2,  -32'sd8,       1'b1, 1'b0, '0},
      '{ORDER_ASC,  6'd0,  32'sh00010000, 1'b1, 1'b1, '{32'sh00010000, 1'b1, 1'b0}}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      case (directed_rows[i].cmd)
        ORDER_ASC:  write_order(ORDER_BIT_ASC);
        ORDER_DESC: write_order(ORDER_BIT_DESC);
        default: ;
      endcase
      repeat (directed_rows[i].fill) put_item(random_sample(), 1'b0);
      typed_active = directed_rows[i].typed;
      typed_want   = directed_rows[i].want;
      put_item(directed_rows[i].value, directed_rows[i].last);
      typed_active = 1'b0;
    end

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      block_len = $urandom_range(1, 8);
      if ($urandom_range(0, 3) == 0) begin
        write_order($urandom_range(0, 1) ? ORDER_BIT_DESC : ORDER_BIT_ASC);
      end
      for (int k = 0; k < block_len; k++) begin
        if (k > 0 && $urandom_range(0, 19) == 0) begin
          write_order($urandom_range(0, 1) ? ORDER_BIT_DESC : ORDER_BIT_ASC);
        end
        pace_sender();
        put_item(random_sample(), k == block_len - 1);
      end
      random_sent += block_len;
    end
    idle(1);

    waited = 0;
    while (pending_sorted.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (pending_sorted.size() != 0) begin
      report_mismatch($sformatf("%0d items never arrived", pending_sorted.size()));
    end

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
